// ===== rtl/sclc_pkg.sv =====
// Package for the size-capped LRU cache: word types, field widths, result kinds.
// No dependencies; used by rtl/size_capped_lru_cache.sv.
package sclc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int LEN_W       = 40;
    localparam int TOT_W       = 41;

    typedef enum logic [1:0] {
        KIND_HIT    = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_EVICT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [KEY_W-1:0] entry_key;
        logic [LEN_W-1:0] entry_length;
    } in_word_t;

    typedef struct packed {
        kind_t            result_kind;
        logic [KEY_W-1:0] result_key;
        logic [LEN_W-1:0] result_length;
        logic [TOT_W-1:0] bytes_held;
        logic             last_result;
    } out_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] length;
    } slot_t;

endpackage

// ===== rtl/size_capped_lru_cache.sv =====
// Size-capped LRU cache: slot memory, recency rank cells and the scan sequencer.
// Depends on rtl/sclc_pkg.sv.
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+-----------------------
//  input    | in_valid, in_ready, in_data      | in        | key, byte length
//  output   | out_valid, out_ready, out_data   | out       | kind, key, length, total
//  config   | cfg_write_en, cfg_write_data     | in        | byte capacity
//
// One word at a time. Lookup walks the slot memory one slot a cycle, then a decide step
// and a status step. An insert adds an insert step and a loop check. Each eviction adds
// a rank walk, the evict step and a loop check; the one that frees a slot goes to insert.
// Reset clears valid bits, ranks, the byte total and capacity at once.
// A stalled output holds the sequencer at its next result; input is taken only when idle.
module size_capped_lru_cache #(
    parameter int ENTRIES = sclc_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sclc_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sclc_pkg::out_word_t         out_data,
    input  logic                        cfg_write_en,
    input  logic [sclc_pkg::LEN_W-1:0]  cfg_write_data
);
    import sclc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_VSCAN  = 8'b0000_1000,
        S_EVICT  = 8'b0001_0000,
        S_INSERT = 8'b0010_0000,
        S_LOOP   = 8'b0100_0000,
        S_STATUS = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   cap_reg, cap_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IW-1:0]      rank_reg [ENTRIES];
    logic [IW-1:0]      rank_next [ENTRIES];
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IW:0]        scan_cnt_reg, scan_cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               hit_reg, hit_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    logic [LEN_W-1:0]   hit_len_reg, hit_len_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      target_reg, target_next;
    logic               pre_insert_reg, pre_insert_next;
    kind_t              stat_kind_reg, stat_kind_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg, out_data_next;

    slot_t              slot_mem [ENTRIES];
    slot_t              rd_data_reg;
    logic               mem_we;
    logic [IW-1:0]      scan_idx;
    logic               out_free;
    logic [IW-1:0]      hit_rank;

    assign scan_idx  = scan_cnt_reg[IW-1:0];
    assign out_free  = !out_valid_reg || out_ready;
    assign hit_rank  = rank_reg[hit_idx_reg];
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[free_idx_reg] <= '{key: key_reg, length: len_reg};
        end
        rd_data_reg <= slot_mem[scan_idx];
    end

    always_comb
    begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        total_next      = total_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = scan_idx;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_len_next    = hit_len_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        target_next     = target_reg;
        pre_insert_next = pre_insert_reg;
        stat_kind_next  = stat_kind_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;

        if (cfg_write_en)
        begin
            cap_next = cfg_write_data;
        end

        // lookup compare, one slot behind the read address
        if (cmp_vld_reg)
        begin
            if (valid_reg[cmp_idx_reg])
            begin
                count_next = CW'(count_reg + 1'b1);
                if (rd_data_reg.key == key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_len_next = rd_data_reg.length;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = in_data.entry_key;
                    len_next        = in_data.entry_length;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    count_next      = '0;
                    scan_cnt_next   = '0;
                    pre_insert_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg < (IW+1)'(ENTRIES))
                begin
                    cmp_vld_next  = 1'b1;
                    scan_cnt_next = (IW+1)'(scan_cnt_reg + 1'b1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (hit_reg)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_reg[i] && (rank_reg[i] < hit_rank))
                        begin
                            rank_next[i] = IW'(rank_reg[i] + 1'b1);
                        end
                    end
                    rank_next[hit_idx_reg] = '0;
                    stat_kind_next = KIND_HIT;
                    state_next     = S_STATUS;
                end
                else if (len_reg > cap_reg)
                begin
                    stat_kind_next = KIND_REJECT;
                    state_next     = S_STATUS;
                end
                else if (count_reg == CW'(ENTRIES))
                begin
                    pre_insert_next = 1'b1;
                    target_next     = IW'(ENTRIES - 1);
                    scan_cnt_next   = '0;
                    state_next      = S_VSCAN;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_VSCAN:
            begin
                if (valid_reg[scan_idx] && (rank_reg[scan_idx] == target_reg))
                begin
                    state_next = S_EVICT;
                end
                else if (scan_idx == IW'(ENTRIES - 1))
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    scan_cnt_next = (IW+1)'(scan_cnt_reg + 1'b1);
                end
            end
            S_EVICT:
            begin
                if (out_free)
                begin
                    total_next                  = TOT_W'(total_reg - TOT_W'(rd_data_reg.length));
                    out_valid_next              = 1'b1;
                    out_data_next.result_kind   = KIND_EVICT;
                    out_data_next.result_key    = rd_data_reg.key;
                    out_data_next.result_length = rd_data_reg.length;
                    out_data_next.bytes_held    = total_next;
                    out_data_next.last_result   = 1'b0;
                    valid_next[scan_idx]        = 1'b0;
                    count_next                  = CW'(count_reg - 1'b1);
                    if (pre_insert_reg)
                    begin
                        pre_insert_next = 1'b0;
                        free_idx_next   = scan_idx;
                        state_next      = S_INSERT;
                    end
                    else
                    begin
                        state_next = S_LOOP;
                    end
                end
            end
            S_INSERT:
            begin
                mem_we = 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = IW'(rank_reg[i] + 1'b1);
                    end
                end
                rank_next[free_idx_reg]  = '0;
                valid_next[free_idx_reg] = 1'b1;
                total_next               = TOT_W'(total_reg + TOT_W'(len_reg));
                count_next               = CW'(count_reg + 1'b1);
                stat_kind_next           = KIND_INSERT;
                state_next               = S_LOOP;
            end
            S_LOOP:
            begin
                if (total_reg > TOT_W'(cap_reg))
                begin
                    target_next   = IW'(count_reg - 1'b1);
                    scan_cnt_next = '0;
                    state_next    = S_VSCAN;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.result_kind   = stat_kind_reg;
                    out_data_next.result_key    = key_reg;
                    out_data_next.result_length = (stat_kind_reg == KIND_HIT) ? hit_len_reg
                                                                              : len_reg;
                    out_data_next.bytes_held    = total_reg;
                    out_data_next.last_result   = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= '0;
            total_reg      <= '0;
            valid_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            pre_insert_reg <= 1'b0;
            stat_kind_reg  <= KIND_HIT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            total_reg      <= total_next;
            valid_reg      <= valid_next;
            rank_reg       <= rank_next;
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            count_reg      <= count_next;
            pre_insert_reg <= pre_insert_next;
            stat_kind_reg  <= stat_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        len_reg      <= len_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_len_reg  <= hit_len_next;
        free_idx_reg <= free_idx_next;
        target_reg   <= target_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== verif/tb.sv =====
// Testbench for size_capped_lru_cache: directed and random offers checked against an
// in-bench LRU mirror, with bursty input, output stalls and byte capacity changes.
// Depends on rtl/sclc_pkg.sv and rtl/size_capped_lru_cache.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sclc_pkg::*;

    localparam int SLOTS = ENTRIES_DEF;
    localparam int LIMIT = 1000000;
    localparam int IDLE_GAP = 8;
    localparam int TAIL_WAIT = 64;
    localparam int POOL = 24;
    localparam int PHASES = 6;
    localparam int PHASE_WORDS = 59;
    localparam logic [LEN_W-1:0] CAP_MAX = {LEN_W{1'b1}};

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_e;

    class lru_mirror;
        bit [KEY_W-1:0] held_key [SLOTS];
        bit [LEN_W-1:0] held_len [SLOTS];
        bit             held     [SLOTS];
        int unsigned    age      [SLOTS];
        bit [TOT_W-1:0] total;
        bit [LEN_W-1:0] capacity;
        out_word_t      due_words [$];
        int mismatches, offers, hits, inserts, rejects, evictions, longest_run;

        function void set_capacity(bit [LEN_W-1:0] value);
            capacity = value;
        endfunction

        function void queue_word(kind_t kind, bit [KEY_W-1:0] key, bit [LEN_W-1:0] len);
            out_word_t w;
            w.result_kind   = kind;
            w.result_key    = key;
            w.result_length = len;
            w.bytes_held    = total;
            w.last_result   = (kind != KIND_EVICT);
            due_words.push_back(w);
        endfunction

        function bit evict_oldest();
            int victim;
            victim = -1;
            for (int i = 0; i < SLOTS; i++)
                if (held[i] && (victim < 0 || age[i] >= age[victim]))
                    victim = i;
            if (victim < 0)
                return 0;
            held[victim] = 0;
            total = total - held_len[victim];
            evictions++;
            queue_word(KIND_EVICT, held_key[victim], held_len[victim]);
            return 1;
        endfunction

        function void note_offer(in_word_t w);
            int found, free_slot, count, n;
            found = -1;
            free_slot = -1;
            count = 0;
            n = 0;
            offers++;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (held[i])
                begin
                    count++;
                    if (held_key[i] == w.entry_key)
                        found = i;
                end
            end
            if (found >= 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (held[i] && age[i] < age[found])
                        age[i]++;
                age[found] = 0;
                hits++;
                queue_word(KIND_HIT, w.entry_key, held_len[found]);
                return;
            end
            if (w.entry_length > capacity)
            begin
                rejects++;
                queue_word(KIND_REJECT, w.entry_key, w.entry_length);
                return;
            end
            if (count >= SLOTS)
                n += int'(evict_oldest());
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!held[i])
                begin
                    if (free_slot < 0)
                        free_slot = i;
                end
                else
                    age[i]++;
            end
            held[free_slot]     = 1;
            held_key[free_slot] = w.entry_key;
            held_len[free_slot] = w.entry_length;
            age[free_slot]      = 0;
            total = total + w.entry_length;
            while (total > capacity && n < SLOTS && evict_oldest())
                n++;
            inserts++;
            if (n + 1 > longest_run)
                longest_run = n + 1;
            queue_word(KIND_INSERT, w.entry_key, w.entry_length);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (due_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
                return;
            end
            want = due_words.pop_front();
            if (got.result_kind !== want.result_kind || got.result_key !== want.result_key
                || got.result_length !== want.result_length
                || got.bytes_held !== want.bytes_held
                || got.last_result !== want.last_result)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: want kind %0d key %h len %h held %h last %b",
                             want.result_kind, want.result_key, want.result_length,
                             want.bytes_held, want.last_result);
                    $display("           got kind %0d key %h len %h held %h last %b",
                             got.result_kind, got.result_key, got.result_length,
                             got.bytes_held, got.last_result);
                end
            end
        endfunction

        function void finish_check();
            if (due_words.size() != 0)
            begin
                mismatches++;
                $display("%0d result words never arrived", due_words.size());
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_word_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_word_t           out_data;
    logic                cfg_write_en;
    logic [LEN_W-1:0]    cfg_write_data;

    lru_mirror      sb = new();
    int             cycle_count = 0;
    int             words_sent = 0;
    int             cap_writes = 0;
    int             burst_left = 0;
    bit [KEY_W-1:0] key_pool [POOL];

    size_capped_lru_cache u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count++;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                sb.set_capacity(cfg_write_data);
            if (in_valid && in_ready)
                sb.note_offer(in_data);
            if (out_valid && out_ready)
                sb.check_word(out_data);
        end
    end

    task automatic offer(bit [KEY_W-1:0] key, bit [LEN_W-1:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_data  <= {key, len};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.due_words.size() != 0)
            @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    task automatic write_capacity(bit [LEN_W-1:0] value);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
        cap_writes++;
    endtask

    function automatic bit [LEN_W-1:0] pick_length(bit [LEN_W-1:0] cap);
        bit [63:0] rnd;
        bit [63:0] bound;
        int roll;
        rnd = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        bound = 64'(cap);
        bound = bound / 6 + 1;
        if (roll < 70)
            return LEN_W'(rnd % bound);
        if (roll < 80)
            return cap;
        if (roll < 92 && cap != CAP_MAX)
            return cap + 1 + rnd[7:0];
        return rnd[LEN_W-1:0];
    endfunction

    // receiver: stall pattern in segments, plus one long hold-off to back up the input
    initial
    begin : receiver
        ready_mode_e mode;
        int span;
        bit pressed;
        pressed = 0;
        out_ready = 1'b1;
        @(negedge clk);
        forever
        begin
            if (!pressed && words_sent >= 150)
            begin
                pressed = 1;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            mode = ready_mode_e'($urandom_range(0, 2));
            span = $urandom_range(10, 80);
            repeat (span)
            begin
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= LIMIT);
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        bit [LEN_W-1:0] caps [PHASES];
        bit [63:0]      rnd;
        bit [KEY_W-1:0] key;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero capacity: zero length fits, a longer new key is rejected, the held key still hits
        offer(32'd5, '0);
        offer(32'd6, 40'd1);
        offer(32'd5, CAP_MAX);
        write_capacity(CAP_MAX);
        offer('1, CAP_MAX);
        offer('0, CAP_MAX);
        // fill every slot, then one more to force a slot eviction
        for (int k = 0; k < SLOTS + 1; k++)
            offer(100 + k, 40'd10);
        // lowered capacity: hit evicts nothing, exact fit flushes the rest
        write_capacity(40'd100);
        offer(32'd105, 40'd7);
        offer(32'd200, 40'd100);

        rnd = {$urandom, $urandom};
        caps[0] = 40'd1000;
        caps[1] = CAP_MAX;
        caps[2] = 40'd200;
        caps[3] = rnd[LEN_W-1:0];
        caps[4] = '0;
        caps[5] = 40'd5000;
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(caps[p]);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL - 1)]
                                                  : $urandom;
                offer(key, pick_length(caps[p]));
            end
        end

        settle();
        repeat (TAIL_WAIT) @(negedge clk);
        sb.finish_check();
        $display("covered %0d offers over %0d capacity settings:", sb.offers, cap_writes);
        $display("%0d hits, %0d inserts, %0d rejects, %0d evictions",
                 sb.hits, sb.inserts, sb.rejects, sb.evictions);
        $display("up to %0d result words for one offer, %0d mismatches",
                 sb.longest_run, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sclc_pkg.sv
rtl/size_capped_lru_cache.sv
verif/tb.sv
